/* hdl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for rotation_matrix_to_quaternion
// Widths, case codes and the pipeline word that travels between stages.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned NumW   = 18;  // off-diagonal sum or difference
  localparam int unsigned RadW   = 30;  // radicand shifted left by 12
  localparam int unsigned RootW  = 15;  // main component, at most 21673
  localparam int unsigned DivW   = 30;  // |num| * 4096 plus rounding term
  localparam int unsigned QuotW  = 16;  // quotient bits below the overflow check
  localparam int unsigned SqStages  = 15;  // one result bit per stage
  localparam int unsigned DivStages = 17;  // overflow check, then one bit per stage

  localparam logic [1:0] CaseW = 2'd0;
  localparam logic [1:0] CaseX = 2'd1;
  localparam logic [1:0] CaseY = 2'd2;
  localparam logic [1:0] CaseZ = 2'd3;

  typedef struct packed {
    logic [1:0]              sel;
    logic signed [NumW-1:0]  num0;
    logic signed [NumW-1:0]  num1;
    logic signed [NumW-1:0]  num2;
  } side_t;

endpackage

/* hdl/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: 3x3 rotation matrix to unit quaternion
// Shepperd's method in Q2.14: case pick, pipelined square root, three
// pipelined rounding dividers and an output register.
// ----------------------------------------------------------------------------
// Channel  | Dir | tdata bits (low first)
// s_axis   | in  | 144: row0_col0 .. row2_col2, 16 bits each
// m_axis   | out | 64: quat_w, quat_x, quat_y, quat_z, 16 bits each
//
// One item enters per cycle while the output is not stalled.
// Depth is set by the bit-per-stage square root followed by the divider.
// The whole pipeline advances together; a stalled output freezes it, and
// s_axis_tready follows from the output slot being free or being taken.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [143:0]  s_axis_tdata,  // row0_col0,row0_col1,...,row2_col2
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata   // quat_w, quat_x, quat_y, quat_z
);
  localparam int unsigned Lat = 1 + rmq_pkg::SqStages + rmq_pkg::DivStages;

  logic [Lat-1:0] vld_q;
  logic en;
  logic [rmq_pkg::RadW-1:0] rad;
  rmq_pkg::side_t side_f, side_s;
  logic [rmq_pkg::RootW-1:0] root;
  logic [rmq_pkg::RootW-1:0] root_q [rmq_pkg::DivStages+1];
  logic [1:0] sel_q [rmq_pkg::DivStages+1];
  logic signed [rmq_pkg::DataW-1:0] q0, q1, q2, m16;
  logic [63:0] out_d;
  logic [63:0] out_q;
  logic out_vld_q;

  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[Lat-1];
    end
  end

  rmq_front u_front (
    .clk_i, .en_i(en),
    .r11_i(s_axis_tdata[15:0]),    .r12_i(s_axis_tdata[31:16]),
    .r13_i(s_axis_tdata[47:32]),   .r21_i(s_axis_tdata[63:48]),
    .r22_i(s_axis_tdata[79:64]),   .r23_i(s_axis_tdata[95:80]),
    .r31_i(s_axis_tdata[111:96]),  .r32_i(s_axis_tdata[127:112]),
    .r33_i(s_axis_tdata[143:128]),
    .rad_o(rad), .side_o(side_f)
  );

  rmq_sqrt u_sqrt (
    .clk_i, .en_i(en), .rad_i(rad), .side_i(side_f),
    .root_o(root), .side_o(side_s)
  );

  rmq_div u_div0 (.clk_i, .en_i(en), .num_i(side_s.num0), .den_i(root), .quot_o(q0));
  rmq_div u_div1 (.clk_i, .en_i(en), .num_i(side_s.num1), .den_i(root), .quot_o(q1));
  rmq_div u_div2 (.clk_i, .en_i(en), .num_i(side_s.num2), .den_i(root), .quot_o(q2));

  assign root_q[0] = root;
  assign sel_q[0]  = side_s.sel;
  for (genvar g = 0; g < rmq_pkg::DivStages; g++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        root_q[g+1] <= root_q[g];
        sel_q[g+1]  <= sel_q[g];
      end
    end
  end

  always_comb begin
    m16 = rmq_pkg::DataW'({1'b0, root_q[rmq_pkg::DivStages]});
    case (sel_q[rmq_pkg::DivStages])
      rmq_pkg::CaseW: out_d = {q2, q1, q0, m16};
      rmq_pkg::CaseX: out_d = {q2, q1, m16, q0};
      rmq_pkg::CaseY: out_d = {q2, m16, q1, q0};
      rmq_pkg::CaseZ: out_d = {m16, q2, q1, q0};
      default:        out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output item changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow the output slot");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(vld_q))
    else $error("pipeline moved during a stall");
endmodule

/* hdl/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front: case selection stage
// Forms trace and diagonal differences, picks the case, builds the radicand
// and the three numerators.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [rmq_pkg::DataW-1:0]  r11_i, r12_i, r13_i,
  input  logic signed [rmq_pkg::DataW-1:0]  r21_i, r22_i, r23_i,
  input  logic signed [rmq_pkg::DataW-1:0]  r31_i, r32_i, r33_i,
  output logic [rmq_pkg::RadW-1:0]          rad_o,
  output rmq_pkg::side_t                    side_o
);
  logic signed [17:0] tr, d1, d2, d3, val, rad;
  logic signed [rmq_pkg::NumW-1:0] a, b, c, sx, sy, sz, px, py, pz;
  rmq_pkg::side_t side_d;

  always_comb begin
    tr = 18'(r11_i) + 18'(r22_i) + 18'(r33_i);
    d1 = 18'(r11_i) - 18'(r22_i) - 18'(r33_i);
    d2 = -18'(r11_i) + 18'(r22_i) - 18'(r33_i);
    d3 = -18'(r11_i) - 18'(r22_i) + 18'(r33_i);
    a  = 18'(r32_i) - 18'(r23_i);
    b  = 18'(r13_i) - 18'(r31_i);
    c  = 18'(r21_i) - 18'(r12_i);
    sx = 18'(r21_i) + 18'(r12_i);
    sy = 18'(r31_i) + 18'(r13_i);
    sz = 18'(r32_i) + 18'(r23_i);
    px = sx; py = sy; pz = sz;
    if (tr > 0) begin
      side_d = '{sel: rmq_pkg::CaseW, num0: a, num1: b, num2: c};
      val = tr;
    end else if (d1 > d2 && d1 > d3) begin
      side_d = '{sel: rmq_pkg::CaseX, num0: a, num1: px, num2: py};
      val = d1;
    end else if (d2 > d1 && d2 > d3) begin
      side_d = '{sel: rmq_pkg::CaseY, num0: b, num1: px, num2: pz};
      val = d2;
    end else begin
      side_d = '{sel: rmq_pkg::CaseZ, num0: c, num1: py, num2: pz};
      val = d3;
    end
    rad = 18'sd16384 + val;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= (rad > 0) ? {rad[17:0], 12'd0} : '0;
      side_o <= side_d;
    end
  end
endmodule

/* hdl/rmq_sqrt.sv */
// ----------------------------------------------------------------------------
// rmq_sqrt: pipelined integer square root
// Restoring square root, one result bit per stage; side data rides along.
// ----------------------------------------------------------------------------
module rmq_sqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rmq_pkg::RadW-1:0]      rad_i,
  input  rmq_pkg::side_t                side_i,
  output logic [rmq_pkg::RootW-1:0]     root_o,
  output rmq_pkg::side_t                side_o
);
  localparam int unsigned S = rmq_pkg::SqStages;
  localparam int unsigned RemW = rmq_pkg::RootW + 2;

  logic [rmq_pkg::RadW-1:0]  rad_q  [S+1];
  logic [RemW-1:0]           rem_q  [S+1];
  logic [rmq_pkg::RootW-1:0] root_q [S+1];
  rmq_pkg::side_t            side_q [S+1];

  always_comb begin
    rad_q[0]  = rad_i;
    rem_q[0]  = '0;
    root_q[0] = '0;
    side_q[0] = side_i;
  end

  for (genvar g = 0; g < S; g++) begin : g_st
    logic [RemW-1:0] trial, cand;
    always_comb begin
      trial = {rem_q[g][RemW-3:0], rad_q[g][rmq_pkg::RadW-1 -: 2]};
      cand  = {root_q[g], 2'b01};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[g+1]  <= {rad_q[g][rmq_pkg::RadW-3:0], 2'b00};
        side_q[g+1] <= side_q[g];
        if (trial >= cand) begin
          rem_q[g+1]  <= trial - cand;
          root_q[g+1] <= {root_q[g][rmq_pkg::RootW-2:0], 1'b1};
        end else begin
          rem_q[g+1]  <= trial;
          root_q[g+1] <= {root_q[g][rmq_pkg::RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[S];
  assign side_o = side_q[S];
endmodule

/* hdl/rmq_div.sv */
// ----------------------------------------------------------------------------
// rmq_div: pipelined rounding divider
// Computes round(num * 4096 / m) with halves away from zero, clamped and
// saturated to 16 bits, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [rmq_pkg::NumW-1:0]     num_i,
  input  logic [rmq_pkg::RootW-1:0]           den_i,
  output logic signed [rmq_pkg::DataW-1:0]    quot_o
);
  localparam int unsigned S = rmq_pkg::DivStages;
  localparam int unsigned RW = rmq_pkg::RootW + 1;

  logic [rmq_pkg::DivW-1:0]  dvd_q [S+1];
  logic [RW-1:0]             rem_q [S+1];
  logic [rmq_pkg::RootW-1:0] den_q [S+1];
  logic                      neg_q [S+1];
  logic                      nz_q  [S+1];
  logic                      ovf_q [S+1];
  logic [rmq_pkg::DivW-1:0]  mag;
  logic [rmq_pkg::QuotW-1:0] q;
  logic signed [rmq_pkg::QuotW+1:0] sq;

  always_comb begin
    mag = rmq_pkg::DivW'(num_i[rmq_pkg::NumW-1] ? -num_i : num_i);
    dvd_q[0] = (mag << 12) + rmq_pkg::DivW'(den_i >> 1);
    den_q[0] = den_i;
    neg_q[0] = num_i[rmq_pkg::NumW-1];
    nz_q[0]  = (num_i != '0);
  end

  // A dividend at or above m * 2^16 can only saturate, so the first stage
  // flags it and preloads the remainder with the top 14 dividend bits.
  for (genvar g = 0; g < S; g++) begin : g_st
    logic [RW:0] den_x;
    always_comb den_x = {2'b00, den_q[g]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[g+1] <= den_q[g];
        neg_q[g+1] <= neg_q[g];
        nz_q[g+1]  <= nz_q[g];
      end
    end
    if (g == 0) begin : g_top
      logic [RW:0] trial;
      always_comb trial = {3'd0, dvd_q[g][rmq_pkg::DivW-1 -: 14]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ovf_q[g+1] <= (trial >= den_x);
          rem_q[g+1] <= RW'(trial);
          dvd_q[g+1] <= {dvd_q[g][rmq_pkg::DivW-15:0], 14'd0};
        end
      end
    end else begin : g_bit
      logic [RW:0] trial;
      always_comb trial = {rem_q[g], dvd_q[g][rmq_pkg::DivW-1]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ovf_q[g+1] <= ovf_q[g];
          if (trial >= den_x) begin
            rem_q[g+1] <= RW'(trial - den_x);
            dvd_q[g+1] <= {dvd_q[g][rmq_pkg::DivW-2:0], 1'b1};
          end else begin
            rem_q[g+1] <= RW'(trial);
            dvd_q[g+1] <= {dvd_q[g][rmq_pkg::DivW-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_comb begin
    q  = dvd_q[S][rmq_pkg::QuotW-1:0];
    sq = neg_q[S] ? -$signed({2'b00, q}) : $signed({2'b00, q});
    if (den_q[S] == '0) begin
      quot_o = !nz_q[S] ? '0 : (neg_q[S] ? 16'sh8000 : 16'sh7fff);
    end else if (ovf_q[S]) begin
      quot_o = neg_q[S] ? 16'sh8000 : 16'sh7fff;
    end else if (sq > 32767) begin
      quot_o = 16'sh7fff;
    end else if (sq < -32768) begin
      quot_o = 16'sh8000;
    end else begin
      quot_o = rmq_pkg::DataW'(sq);
    end
  end
endmodule

/* bench/rmq_checker.sv */
// ----------------------------------------------------------------------------
// rmq_checker: quaternion predictor and scoreboard
// Watches both stream channels, computes the expected quaternion for every
// accepted matrix and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rmq_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  input  logic          s_axis_tready,
  input  logic [143:0]  s_axis_tdata,  // row0_col0,row0_col1,...,row2_col2
  input  logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic [63:0]   m_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
  output int            fail_count_o,
  output int            pending_o,
  output int            quat_count_o
);
  logic [63:0] quat_q[$];

  function automatic int unsigned int_sqrt(int unsigned n);
    int unsigned res, bitv;
    res = 0;
    bitv = 32'h4000_0000;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic int unsigned main_root(int val);
    int rad;
    rad = 16384 + val;
    if (rad <= 0) return 0;
    return int_sqrt(int'(rad) << 12);
  endfunction

  // Rounds half away from zero and saturates; a zero divisor gives the sign.
  function automatic logic [15:0] round_div(int num, int unsigned m);
    longint mag, q;
    if (m == 0) begin
      if (num > 0) return 16'sh7fff;
      if (num < 0) return 16'sh8000;
      return 16'h0;
    end
    mag = (num < 0 ? -longint'(num) : longint'(num)) * 4096;
    q = (mag + m / 2) / m;
    if (num < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic logic [63:0] predict_quat(logic [143:0] d);
    int r[9];
    int tr, d1, d2, d3;
    int unsigned m;
    logic [15:0] w, x, y, z;
    for (int i = 0; i < 9; i++) r[i] = int'($signed(d[16*i +: 16]));
    tr = r[0] + r[4] + r[8];
    d1 = r[0] - r[4] - r[8];
    d2 = -r[0] + r[4] - r[8];
    d3 = -r[0] - r[4] + r[8];
    if (tr > 0) begin
      m = main_root(tr);
      w = m[15:0];
      x = round_div(r[7] - r[5], m);
      y = round_div(r[2] - r[6], m);
      z = round_div(r[3] - r[1], m);
    end else if (d1 > d2 && d1 > d3) begin
      m = main_root(d1);
      x = m[15:0];
      w = round_div(r[7] - r[5], m);
      y = round_div(r[3] + r[1], m);
      z = round_div(r[6] + r[2], m);
    end else if (d2 > d1 && d2 > d3) begin
      m = main_root(d2);
      y = m[15:0];
      w = round_div(r[2] - r[6], m);
      x = round_div(r[3] + r[1], m);
      z = round_div(r[7] + r[5], m);
    end else begin
      m = main_root(d3);
      z = m[15:0];
      w = round_div(r[3] - r[1], m);
      x = round_div(r[6] + r[2], m);
      y = round_div(r[7] + r[5], m);
    end
    return {z, y, x, w};
  endfunction

  assign pending_o = quat_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] exp_q;
    if (!rst_ni) begin
      fail_count_o <= 0;
      quat_count_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        quat_q.insert(quat_q.size(), predict_quat(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        quat_count_o <= quat_count_o + 1;
        if (quat_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("ERROR: unexpected quaternion %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_q = quat_q.pop_front();
          for (int f = 0; f < 4; f++) begin
            if (exp_q[16*f +: 16] !== m_axis_tdata[16*f +: 16]) begin
              if (fail_count_o < 10)
                $display("ERROR: quaternion %0d field %0d: expected %h, got %h",
                         quat_count_o, f, exp_q[16*f +: 16], m_axis_tdata[16*f +: 16]);
              fail_count_o <= fail_count_o + 1;
              break;
            end
          end
        end
      end
    end
  end

  final begin
  end
endmodule

/* bench/tb_rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion: stimulus and verdict
// Drives directed and random matrices with random gaps and output stalls,
// including a long output hold-off and a full drain, and reports the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion;
  localparam int NumRandom = 1350;
  localparam int IdleLimit = 5000;
  localparam int Latency   = 34;
  localparam logic signed [15:0] One = 16'sd16384;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [143:0]  s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [63:0]   m_axis_tdata;
  int            fail_count, pending, quat_count;
  int            idle_cycles = 0;
  int            matrix_count = 0;
  bit            hold_off = 1'b0;

  rotation_matrix_to_quaternion uut (.*);

  rmq_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .quat_count_o(quat_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [143:0] diag_matrix(logic [15:0] a, logic [15:0] b,
                                               logic [15:0] c);
    return {c, 16'h0, 16'h0, 16'h0, b, 16'h0, 16'h0, 16'h0, a};
  endfunction

  // Proper rotation about one axis with a random angle cosine and sine pair, plus a small random offset on each entry.
  function automatic logic [143:0] axis_rotation();
    int ax, c, s;
    logic signed [15:0] m[9];
    real ang;
    ang = $urandom_range(0, 62831) / 10000.0;
    c = int'($cos(ang) * 16384.0);
    s = int'($sin(ang) * 16384.0);
    ax = $urandom_range(0, 2);
    foreach (m[i]) m[i] = '0;
    m[4*ax] = One;
    m[4*((ax + 1) % 3)] = 16'(c);
    m[4*((ax + 2) % 3)] = 16'(c);
    m[3*((ax + 1) % 3) + (ax + 2) % 3] = 16'(-s);
    m[3*((ax + 2) % 3) + (ax + 1) % 3] = 16'(s);
    for (int i = 0; i < 9; i++)
      m[i] = 16'(m[i] + $signed(16'($urandom_range(0, 6))) - 3);
    return {m[8], m[7], m[6], m[5], m[4], m[3], m[2], m[1], m[0]};
  endfunction

  // The idle gap follows the item, so tvalid drops only when a gap is drawn.
  task automatic send_matrix(logic [143:0] d);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    matrix_count++;
    gap = $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Back-to-back variant keeps tvalid high across items.
  task automatic burst_matrices(int n);
    s_axis_tvalid <= 1'b1;
    for (int i = 0; i < n; i++) begin
      s_axis_tdata <= {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
      do @(posedge clk_i); while (!s_axis_tready);
      matrix_count++;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // The receiver waits a drawn number of cycles before taking each item.
  initial begin
    int gap;
    forever begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      while (hold_off) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready) && !hold_off);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("ERROR: watchdog expired, %0d results pending", pending);
        $display("tb_rotation_matrix_to_quaternion NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity and half-turns exercise each main-component case.
    send_matrix(diag_matrix(One, One, One));
    send_matrix(diag_matrix(One, -One, -One));
    send_matrix(diag_matrix(-One, One, -One));
    send_matrix(diag_matrix(-One, -One, One));
    // Ties between diagonal differences fall through to the z case.
    send_matrix(diag_matrix(16'h0, 16'h0, 16'h0));
    send_matrix(diag_matrix(-One, -One, -One));
    send_matrix(diag_matrix(16'sd100, 16'sd100, -16'sd300));
    // Entries at the 16-bit limits exercise the widest sums and differences.
    send_matrix({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                 16'h8000, 16'h7fff, 16'h8000, 16'h8000});
    send_matrix({16'h8000, 16'h0, 16'h8000, 16'h0, 16'h8000,
                 16'h7fff, 16'h8000, 16'h0, 16'h8000});
    send_matrix({9{16'h7fff}});
    send_matrix({9{16'h8000}});
    send_matrix({9{16'hffff}});
    send_matrix({9{16'h0001}});
    send_matrix({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    send_matrix(diag_matrix(16'sd1, 16'sd0, 16'sd0));
    send_matrix(diag_matrix(16'sd1, 16'sd0, -16'sd1));
    wait_drained();

    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 3) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (200) @(posedge clk_i);
            hold_off = 1'b0;
          end
          burst_matrices(60);
        join
      end
      if (i == 2 * NumRandom / 3) wait_drained();
      if ($urandom_range(0, 3) != 0) send_matrix(axis_rotation());
      else if ($urandom_range(0, 1)) burst_matrices($urandom_range(1, 8));
      else send_matrix({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
    end

    wait_drained();
    repeat (Latency + 10) @(posedge clk_i);
    $display("Sent %0d matrices (directed, rotations, random words, bursts);", matrix_count);
    $display("checked %0d quaternions across all four main-component cases.", quat_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_rotation_matrix_to_quaternion OK");
    end else begin
      $display("tb_rotation_matrix_to_quaternion NOT OK");
    end
    $finish;
  end
endmodule
